// ===== src/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// Used by mhpq_ctrl, mhpq_dp and min_heap_priority_queue; no dependencies.
package mhpq_pkg;

	localparam int KEY_W = 32;
	localparam int OCC_W = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// datapath operation for the current cycle
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_POP_RD,
		OP_POP_LD,
		OP_UP_RD,
		OP_UP_CMP,
		OP_DN_RD,
		OP_DN_CMP,
		OP_FIN
	} dp_op_t;

	// datapath flags for the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_root;
		logic leaf;
		logic up_move;
		logic dn_move;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/mhpq_ctrl.sv =====
// Sequencer for the min-heap priority queue: one-hot FSM over accept, sift-up,
// sift-down and result hand-off. Depends on mhpq_pkg.
module mhpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_pop,
	input  mhpq_pkg::dp_stat_t stat,
	output logic              in_ready,
	output mhpq_pkg::dp_op_t  op
);
	import mhpq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_POP_RD = 8'b0000_0010,
		S_POP_LD = 8'b0000_0100,
		S_UP_RD  = 8'b0000_1000,
		S_UP_CMP = 8'b0001_0000,
		S_DN_RD  = 8'b0010_0000,
		S_DN_CMP = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_ACCEPT;
					if (in_pop == CMD_POP) begin
						state_d = stat.empty ? S_FIN : S_POP_RD;
					end else begin
						state_d = stat.full ? S_FIN : S_UP_RD;
					end
				end
			end
			S_POP_RD: begin
				op      = OP_POP_RD;
				state_d = S_POP_LD;
			end
			S_POP_LD: begin
				op      = OP_POP_LD;
				state_d = S_DN_RD;
			end
			S_UP_RD: begin
				op      = OP_UP_RD;
				state_d = stat.pos_root ? S_FIN : S_UP_CMP;
			end
			S_UP_CMP: begin
				op      = OP_UP_CMP;
				state_d = stat.up_move ? S_UP_RD : S_FIN;
			end
			S_DN_RD: begin
				op      = OP_DN_RD;
				state_d = stat.leaf ? S_FIN : S_DN_CMP;
			end
			S_DN_CMP: begin
				op      = OP_DN_CMP;
				state_d = stat.dn_move ? S_DN_RD : S_FIN;
			end
			S_FIN: begin
				op = OP_FIN;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/mhpq_dp.sv =====
// Datapath for the min-heap priority queue: heap memory, entry count, sift
// registers and the output register. Depends on mhpq_pkg.
module mhpq_dp #(
	parameter int HEAP_DEPTH = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mhpq_pkg::dp_op_t                    op,
	input  logic                                in_pop,
	input  logic signed [mhpq_pkg::KEY_W-1:0]   in_key,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [mhpq_pkg::KEY_W-1:0]   out_key,
	output mhpq_pkg::status_t                   out_status,
	output logic        [mhpq_pkg::OCC_W-1:0]   out_occ,
	output mhpq_pkg::dp_stat_t                  stat
);
	import mhpq_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = AW + 2;

	logic signed [KEY_W-1:0] mem [HEAP_DEPTH];
	logic signed [KEY_W-1:0] rd_a_q, rd_b_q;
	logic signed [KEY_W-1:0] key_q, res_q;
	logic        [CW-1:0]    cnt_q;
	logic        [AW-1:0]    pos_q;
	status_t                 st_q;

	logic                    we, re;
	logic        [AW-1:0]    wa, ra_a, ra_b;
	logic signed [KEY_W-1:0] wd;

	logic        [AW-1:0]    parent;
	logic        [IW-1:0]    left, right, n_ext;
	logic                    right_ok, pick_right;
	logic signed [KEY_W-1:0] child_key;
	logic        [AW-1:0]    kid;

	assign parent     = (pos_q - AW'(1)) >> 1;
	assign left       = IW'({pos_q, 1'b1});
	assign right      = left + IW'(1);
	assign n_ext      = IW'(cnt_q);
	assign right_ok   = right < n_ext;
	assign pick_right = right_ok && (rd_b_q < rd_a_q);
	assign child_key  = pick_right ? rd_b_q : rd_a_q;
	assign kid        = pick_right ? right[AW-1:0] : left[AW-1:0];

	assign stat.full     = cnt_q == CW'(HEAP_DEPTH);
	assign stat.empty    = cnt_q == '0;
	assign stat.pos_root = pos_q == '0;
	assign stat.leaf     = left >= n_ext;
	assign stat.up_move  = key_q < rd_a_q;
	assign stat.dn_move  = child_key < key_q;
	assign stat.out_free = !out_valid || out_ready;

	// memory port control
	always_comb begin
		we   = 1'b0;
		re   = 1'b0;
		wa   = pos_q;
		wd   = key_q;
		ra_a = left[AW-1:0];
		ra_b = right_ok ? right[AW-1:0] : left[AW-1:0];
		case (op)
			OP_POP_RD: begin
				re   = 1'b1;
				ra_a = '0;
				ra_b = cnt_q[AW-1:0];
			end
			OP_UP_RD: begin
				re   = !stat.pos_root;
				we   = stat.pos_root;
				ra_a = parent;
			end
			OP_UP_CMP: begin
				we = 1'b1;
				wd = stat.up_move ? rd_a_q : key_q;
			end
			OP_DN_RD: begin
				re = !stat.leaf;
				we = stat.leaf;
			end
			OP_DN_CMP: begin
				we = 1'b1;
				wd = stat.dn_move ? child_key : key_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_a_q <= mem[ra_a];
			rd_b_q <= mem[ra_b];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				key_q <= in_key;
				res_q <= '0;
				pos_q <= cnt_q[AW-1:0];
				if (in_pop == CMD_POP) begin
					st_q <= stat.empty ? ST_EMPTY : ST_OK;
				end else begin
					st_q <= stat.full ? ST_FULL : ST_OK;
				end
			end
			OP_POP_LD: begin
				res_q <= rd_a_q;
				key_q <= rd_b_q;
				pos_q <= '0;
			end
			OP_UP_CMP: begin
				if (stat.up_move) begin
					pos_q <= parent;
				end
			end
			OP_DN_CMP: begin
				if (stat.dn_move) begin
					pos_q <= kid;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op == OP_ACCEPT) begin
			if (in_pop == CMD_POP) begin
				if (!stat.empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end else if (!stat.full) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (op == OP_FIN && stat.out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_FIN && stat.out_free) begin
			out_key    <= res_q;
			out_status <= st_q;
			out_occ    <= OCC_W'(cnt_q);
		end
	end

endmodule

// ===== src/min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed 32-bit keys (insert / pop minimum). An insert
// is placed at the end and sifted up, one read and one compare step per level moved; a pop
// reads the root and last entry, loads the last as the key and sifts it down the same way.
// A full insert or an empty pop goes straight to its result. One item at a time: a new beat
// waits until the result enters the output register, which can stall on m_axis_tready.
// Reset (arst_n low) empties the heap and the output register; heap memory is not cleared.
module min_heap_priority_queue #(
	parameter int HEAP_DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [mhpq_pkg::KEY_W-1:0]              s_axis_tdata,  // key_in
	input  logic                                    s_axis_tuser,  // command
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [mhpq_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // key_out, occupancy
	output logic [1:0]                              m_axis_tuser   // status
);
	import mhpq_pkg::*;

	dp_op_t                  op;
	dp_stat_t                stat;
	logic signed [KEY_W-1:0] out_key;
	status_t                 out_status;
	logic        [OCC_W-1:0] out_occ;

	// sequencer: takes a beat only when idle, walks the sift, hands off result
	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_pop   (s_axis_tuser),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.op       (op)
	);

	// heap storage, count, sift registers and the output beat register
	mhpq_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.in_pop     (s_axis_tuser),
		.in_key     (s_axis_tdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_key    (out_key),
		.out_status (out_status),
		.out_occ    (out_occ),
		.stat       (stat)
	);

	// pack the result beat: key in the low word, occupancy above it
	assign m_axis_tdata = {out_occ, out_key};
	assign m_axis_tuser = out_status;

endmodule
